### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/spq_pkg.sv
// types, sizes and codes of the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue_unit
package spq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int HANDLE_BITS = 8;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_BITS = 2;

  // operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                   operation;
    logic [WEIGHT_BITS-1:0] key_weight;
    logic [HANDLE_BITS-1:0] entry_handle;
  } spq_req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [WEIGHT_BITS-1:0] out_weight;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [COUNT_BITS-1:0]  occupancy;
  } spq_rsp_t;

  // one stored entry
  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [HANDLE_BITS-1:0] handle;
  } spq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic       insert;
    logic       extract;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

### rtl/core/spq_cell.sv
// one cell of the sorted shift chain: holds a single entry
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_cmd_t   cmd,
  input  logic               occupied,
  input  logic               left_stay,
  input  spq_pkg::spq_entry_t left_entry,
  input  spq_pkg::spq_entry_t right_entry,
  output logic               stay,
  output spq_pkg::spq_entry_t entry
);
  import spq_pkg::*;

  // entry keeps its place on insert if it is held and not heavier than the new one
  assign stay = occupied && (entry.weight <= cmd.entry.weight);

  // insert: the first moving cell takes the new entry, later ones shift up
  // extract: every cell takes its right neighbour, the last cell keeps its own entry
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!stay) begin
        entry <= left_stay ? cmd.entry : left_entry;
      end
    end else if (cmd.extract) begin
      entry <= right_entry;
    end
  end

endmodule

### rtl/core/sorted_priority_queue_unit.sv
// Bounded priority queue of 32 entries kept in ascending weight order in a chain
// of cells that all compare against an inserted weight in the same cycle. One
// request (insert or extract-minimum) is accepted per clock; its response is
// registered and appears the cycle after acceptance. Requests keep flowing
// while the response register is free or being drained, so the sustained rate
// is one request per cycle, set only by the response side stalling.
// Equal weights leave first in, first out. A full insert is dropped with
// status full, an empty extract returns status empty.
module sorted_priority_queue_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  spq_pkg::spq_req_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output spq_pkg::spq_rsp_t rsp
);
  import spq_pkg::*;

  localparam logic [COUNT_BITS-1:0] DEPTH_COUNT = COUNT_BITS'(QUEUE_DEPTH);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  spq_cmd_t              cmd;
  spq_rsp_t              rsp_next;

  spq_entry_t            cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_stay;

  // handshake: take a request whenever the response register can move
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == DEPTH_COUNT);
  assign empty     = (count == '0);

  // command to the chain
  assign cmd.insert       = accept && (req.operation == OP_INSERT) && !full;
  assign cmd.extract      = accept && (req.operation == OP_EXTRACT) && !empty;
  assign cmd.entry.weight = req.key_weight;
  assign cmd.entry.handle = req.entry_handle;

  // chain of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [COUNT_BITS-1:0] INDEX = COUNT_BITS'(i);
    logic       occupied;
    logic       left_stay;
    spq_entry_t left_entry;
    spq_entry_t right_entry;

    assign occupied = (count > INDEX);

    if (i == 0) begin : g_head
      assign left_stay  = 1'b1;
      assign left_entry = cmd.entry;
    end else begin : g_body
      assign left_stay  = cell_stay[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occupied),
      .left_stay  (left_stay),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .stay       (cell_stay[i]),
      .entry      (cell_entry[i])
    );
  end

  // occupancy update
  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + COUNT_BITS'(1);
    end else if (cmd.extract) begin
      count_next = count - COUNT_BITS'(1);
    end
  end

  // response contents
  always_comb begin
    rsp_next.status     = ST_OK;
    rsp_next.out_weight = '0;
    rsp_next.out_handle = '0;
    rsp_next.occupancy  = count_next;
    if (req.operation == OP_INSERT) begin
      if (full) begin
        rsp_next.status = ST_FULL;
      end
    end else begin
      if (empty) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        rsp_next.out_weight = cell_entry[0].weight;
        rsp_next.out_handle = cell_entry[0].handle;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_count_bound, count <= DEPTH_COUNT, "entry count beyond queue depth")
  `ASSERT_CLK(a_occ_tracks, accept |=> (rsp.occupancy == count), "occupancy differs from count")
  `ASSERT_CLK(a_empty_extract, (accept && (req.operation == OP_EXTRACT) && empty) |=> ((rsp.status == ST_EMPTY) && (count == '0)), "empty extract not flagged")
  `ASSERT_CLK(a_extract_dec, cmd.extract |=> (count == $past(count) - COUNT_BITS'(1)), "extract did not shrink queue")

endmodule
